/* rtl/core/fbpt_pkg.sv */
`timescale 1ns / 1ps

package fbpt_pkg;

	localparam int NUM_BUTTONS = 4;
	localparam int SHOWN_ENTRIES = 8;
	localparam int ID_W = 3;

	localparam int IN_W = 40;
	localparam int OUT_W = 72;

	localparam int ADDR_W = 1;
	localparam logic [ADDR_W-1:0] REG_DEBOUNCE = 1'b0;
	localparam logic [7:0] DEBOUNCE_RESET = 8'd20;

endpackage

/* rtl/core/four_button_press_tracker_top.sv */
`timescale 1ns / 1ps

// The input register takes an item on its input transfer and passes it on to the result
// register when that is free or being emptied; the result register then raises m_tvalid
// and holds the item until m_tready is high.
// Throughput: one item per cycle, held back only by m_tready on the result register.
// Reset clears all tracking state, the press history and both valid flags;
// debounce_ms returns to 20. There is no clearing pass.
module four_button_press_tracker_top #(
	parameter int HISTORY_DEPTH = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// APB configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [fbpt_pkg::ADDR_W-1:0]    paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	// Button samples
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// levels[3:0], now_ms[35:4], set_wait[36], zero[39:37]
	input  logic [fbpt_pkg::IN_W-1:0]      s_tdata,
	// Results
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// release_event[0], prior_levels[4:1], held_button[7:5], held_since[39:8],
	// multi_active[40], history_word[64:41], history_len[68:65], zero[71:69]
	output logic [fbpt_pkg::OUT_W-1:0]     m_tdata
);

	localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
	localparam int SHOW_N = (HISTORY_DEPTH < fbpt_pkg::SHOWN_ENTRIES) ?
		HISTORY_DEPTH : fbpt_pkg::SHOWN_ENTRIES;

	// Configuration
	logic [7:0] deb_q;

	// Input register
	logic        vld_s1;
	logic [3:0]  levels_s1;
	logic [31:0] now_s1;
	logic        setw_s1;

	// Tracking state
	logic [3:0]  levels_q;
	logic [2:0]  dcnt_q;
	logic [31:0] rel_ms_q;
	logic [2:0]  held_q;
	logic [31:0] held_ms_q;
	logic        multi_q;
	logic        wait_q;
	logic [fbpt_pkg::ID_W-1:0] hist_q [HISTORY_DEPTH];
	logic [CNT_W-1:0] hcnt_q;

	// Result register
	logic                       out_vld_q;
	logic [fbpt_pkg::OUT_W-1:0] out_q;

	// Next-state values
	logic [3:0]  levels_n;
	logic [2:0]  dcnt_n;
	logic [31:0] rel_ms_n;
	logic [2:0]  held_n;
	logic [31:0] held_ms_n;
	logic        multi_n;
	logic        wait_n;
	logic [fbpt_pkg::ID_W-1:0] hist_n [HISTORY_DEPTH];
	logic [CNT_W-1:0] hcnt_n;
	logic        release_n;
	logic [3:0]  shown_n;
	logic [23:0] word_n;
	logic [31:0] gap;
	logic        gap_ok;
	logic        cfg_wr;
	logic        advance;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == fbpt_pkg::REG_DEBOUNCE);
	assign prdata = (paddr == fbpt_pkg::REG_DEBOUNCE) ? {24'b0, deb_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_q <= fbpt_pkg::DEBOUNCE_RESET;
		end else if (cfg_wr) begin
			deb_q <= pwdata[7:0];
		end
	end

	// The item in the input register moves on whenever the result register is free
	// or is being emptied in the same cycle.
	assign advance  = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready = !vld_s1 || advance;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			levels_s1 <= s_tdata[3:0];
			now_s1    <= s_tdata[35:4];
			setw_s1   <= s_tdata[36];
		end
	end

	// A release earlier in the button order in the same sample would make the gap zero;
	// the released flag blocks those presses, so one subtraction against the stored time is enough.
	assign gap    = now_s1 - rel_ms_q;
	assign gap_ok = gap > {24'b0, deb_q};

	always_comb begin
		logic released;
		levels_n  = levels_q;
		dcnt_n    = dcnt_q;
		rel_ms_n  = rel_ms_q;
		held_n    = held_q;
		held_ms_n = held_ms_q;
		multi_n   = multi_q;
		wait_n    = wait_q || setw_s1;
		hist_n    = hist_q;
		hcnt_n    = hcnt_q;
		release_n = 1'b0;
		released  = 1'b0;
		word_n    = '0;
		shown_n   = '0;

		for (int i = 0; i < fbpt_pkg::NUM_BUTTONS; i++) begin
			if (levels_s1[i] && !levels_q[i]) begin
				if (held_n == 3'd0) begin
					held_n    = 3'(i + 1);
					held_ms_n = now_s1;
				end
				dcnt_n = dcnt_n + 3'd1;
				if (dcnt_n > 3'd1) begin
					multi_n = 1'b1;
				end
				levels_n[i] = 1'b1;
				if (gap_ok && !released) begin
					for (int j = HISTORY_DEPTH - 1; j > 0; j--) begin
						hist_n[j] = hist_n[j-1];
					end
					hist_n[0] = fbpt_pkg::ID_W'(i + 1);
					if (hcnt_n < CNT_W'(HISTORY_DEPTH)) begin
						hcnt_n = hcnt_n + CNT_W'(1);
					end
				end
			end else if (!levels_s1[i] && levels_q[i]) begin
				if (dcnt_n > 3'd0) begin
					dcnt_n = dcnt_n - 3'd1;
				end
				rel_ms_n    = now_s1;
				levels_n[i] = 1'b0;
				if (dcnt_n == 3'd0) begin
					held_n    = 3'd0;
					held_ms_n = '0;
				end
				release_n = 1'b1;
				released  = 1'b1;
			end
		end

		// The end of a multi-press and a pending wait both swallow the release.
		if (dcnt_n == 3'd0 && multi_n) begin
			multi_n   = 1'b0;
			release_n = 1'b0;
		end
		if (wait_n) begin
			wait_n    = dcnt_n != 3'd0;
			release_n = 1'b0;
		end

		if (32'(hcnt_n) < 32'(fbpt_pkg::SHOWN_ENTRIES)) begin
			shown_n = 4'(hcnt_n);
		end else begin
			shown_n = 4'(fbpt_pkg::SHOWN_ENTRIES);
		end
		for (int k = 0; k < SHOW_N; k++) begin
			if (4'(k) < shown_n) begin
				word_n[3*k +: 3] = hist_n[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q  <= '0;
			dcnt_q    <= '0;
			rel_ms_q  <= '0;
			held_q    <= '0;
			held_ms_q <= '0;
			multi_q   <= 1'b0;
			wait_q    <= 1'b0;
			hcnt_q    <= '0;
			for (int j = 0; j < HISTORY_DEPTH; j++) begin
				hist_q[j] <= '0;
			end
			out_vld_q <= 1'b0;
		end else begin
			if (advance) begin
				levels_q  <= levels_n;
				dcnt_q    <= dcnt_n;
				rel_ms_q  <= rel_ms_n;
				held_q    <= held_n;
				held_ms_q <= held_ms_n;
				multi_q   <= multi_n;
				wait_q    <= wait_n;
				hcnt_q    <= hcnt_n;
				hist_q    <= hist_n;
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= {3'b0, shown_n, word_n, multi_n, held_ms_n, held_n, levels_q, release_n};
		end
	end

	// The down count always mirrors the number of buttons held.
	a_dcnt_matches: assert property (@(posedge clk) disable iff (!arst_n)
		dcnt_q == 3'($countones(levels_q)))
		else $error("down count differs from stored levels");

	// A held button is recorded exactly when some button is down.
	a_held_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(held_q == 3'd0) == (levels_q == 4'd0))
		else $error("held button inconsistent with stored levels");

	// The history count never exceeds the history depth.
	a_hcnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(hcnt_q) <= 32'(HISTORY_DEPTH))
		else $error("history count beyond depth");

	// State changes only when an item passes into the result register.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(levels_q) && $stable(hcnt_q))
		else $error("state changed without an item");

endmodule

/* tb/tb_four_button_press_tracker_top.sv */
`timescale 1ns / 1ps

module tb_four_button_press_tracker_top;

	localparam int HISTORY_DEPTH = 8;
	localparam int RANDOM_PER_PHASE = 150;

	typedef struct {
		logic [3:0]  levels;
		logic [31:0] now_ms;
		logic        set_wait;
	} sample_t;

	typedef struct {
		logic        release_event;
		logic [3:0]  prior_levels;
		logic [2:0]  held_button;
		logic [31:0] held_since;
		logic        multi_active;
		logic [23:0] history_word;
		logic [3:0]  history_len;
	} press_result_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        psel = 1'b0;
	logic                        penable = 1'b0;
	logic                        pwrite = 1'b0;
	logic [fbpt_pkg::ADDR_W-1:0] paddr = '0;
	logic [31:0]                 pwdata = '0;
	logic [31:0]                 prdata;
	logic                        pready;
	logic                        s_tvalid = 1'b0;
	logic                        s_tready;
	// levels[3:0], now_ms[35:4], set_wait[36], zero[39:37]
	logic [fbpt_pkg::IN_W-1:0]   s_tdata = '0;
	logic                        m_tvalid;
	logic                        m_tready = 1'b0;
	// release_event[0], prior_levels[4:1], held_button[7:5], held_since[39:8],
	// multi_active[40], history_word[64:41], history_len[68:65], zero[71:69]
	logic [fbpt_pkg::OUT_W-1:0]  m_tdata;

	sample_t       pending_samples[$];
	press_result_t expected_results[$];
	int            mismatch_count = 0;
	logic          no_idle = 1'b0;

	// Tracker state mirrored by the predictor.
	logic [7:0]  trk_debounce;
	logic [3:0]  trk_levels;
	int          trk_down;
	logic [31:0] trk_last_rel;
	logic [2:0]  trk_held;
	logic [31:0] trk_since;
	logic        trk_multi;
	logic        trk_wait;
	logic [2:0]  press_log[HISTORY_DEPTH];
	int          press_count;

	// Stimulus walk state.
	logic [3:0]  gen_levels;
	logic [31:0] gen_clock;
	logic [31:0] gen_last_rel;

	four_button_press_tracker_top #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always #4 clk = ~clk;

	function automatic int gap_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic press_result_t track_sample(input sample_t s);
		press_result_t res;
		logic [31:0]   since_rel;
		int            shown;
		res.release_event = 1'b0;
		res.prior_levels = trk_levels;
		if (s.set_wait)
			trk_wait = 1'b1;
		for (int b = 0; b < fbpt_pkg::NUM_BUTTONS; b++) begin
			if (s.levels[b] && !trk_levels[b]) begin
				if (trk_held == 3'd0) begin
					trk_held = 3'(b + 1);
					trk_since = s.now_ms;
				end
				trk_down++;
				if (trk_down > 1)
					trk_multi = 1'b1;
				trk_levels[b] = 1'b1;
				since_rel = s.now_ms - trk_last_rel;
				if (since_rel > {24'd0, trk_debounce}) begin
					for (int k = HISTORY_DEPTH - 1; k > 0; k--)
						press_log[k] = press_log[k-1];
					press_log[0] = 3'(b + 1);
					if (press_count < HISTORY_DEPTH)
						press_count++;
				end
			end else if (!s.levels[b] && trk_levels[b]) begin
				if (trk_down > 0)
					trk_down--;
				trk_last_rel = s.now_ms;
				trk_levels[b] = 1'b0;
				if (trk_down == 0) begin
					trk_held = 3'd0;
					trk_since = '0;
				end
				res.release_event = 1'b1;
			end
		end
		// The end of a multi-press and a pending wait both swallow the release.
		if (trk_down == 0 && trk_multi) begin
			trk_multi = 1'b0;
			res.release_event = 1'b0;
		end
		if (trk_wait) begin
			trk_wait = trk_down > 0;
			res.release_event = 1'b0;
		end
		shown = press_count < fbpt_pkg::SHOWN_ENTRIES ? press_count : fbpt_pkg::SHOWN_ENTRIES;
		res.history_word = '0;
		for (int i = 0; i < shown; i++)
			res.history_word[3*i +: 3] = press_log[i];
		res.history_len = 4'(shown);
		res.held_button = trk_held;
		res.held_since = trk_since;
		res.multi_active = trk_multi;
		return res;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
		end
	endtask

	task automatic queue_sample(input logic [3:0] lv, input logic [31:0] t, input logic sw);
		sample_t s;
		s.levels = lv;
		s.now_ms = t;
		s.set_wait = sw;
		pending_samples.push_back(s);
	endtask

	task automatic drain();
		while (pending_samples.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_debounce(input logic [7:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= fbpt_pkg::REG_DEBOUNCE;
		pwdata <= {24'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		trk_debounce = value;
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		check_field("debounce readback", {24'd0, value}, prdata);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic fill_random(input int count);
		int          r;
		logic [3:0]  lv;
		logic [31:0] t;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			if (r < 4)
				gen_clock = $urandom;
			else if (r < 7)
				gen_clock = 32'hFFFF_FFFF - $urandom_range(0, 40);
			else if (r < 25)
				// Land right around the end of the debounce window.
				gen_clock = gen_last_rel + trk_debounce + $urandom_range(0, 3) - 1;
			else if (r < 40)
				gen_clock = gen_clock + $urandom_range(0, 3);
			else
				gen_clock = gen_clock + $urandom_range(0, 2 * trk_debounce + 8);
			t = gen_clock;
			r = $urandom_range(0, 99);
			if (r < 70)
				lv = gen_levels ^ (4'b1 << $urandom_range(0, 3));
			else if (r < 85)
				lv = 4'($urandom_range(0, 15));
			else if (r < 95)
				lv = gen_levels;
			else
				lv = 4'd0;
			if (|(gen_levels & ~lv))
				gen_last_rel = t;
			gen_levels = lv;
			queue_sample(lv, t, $urandom_range(0, 99) < 8);
		end
	endtask

	// Source side: one transfer per accepted sample, predicted on acceptance.
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		logic                      nxt_valid;
		logic [fbpt_pkg::IN_W-1:0] nxt_data;
		sample_t                   s;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			nxt_valid = s_tvalid;
			nxt_data = s_tdata;
			if (s_tvalid && s_tready) begin
				s.levels = s_tdata[3:0];
				s.now_ms = s_tdata[35:4];
				s.set_wait = s_tdata[36];
				expected_results.push_back(track_sample(s));
				nxt_valid = 1'b0;
			end
			if (!nxt_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_samples.size() != 0) begin
					s = pending_samples.pop_front();
					nxt_valid = 1'b1;
					nxt_data = {3'd0, s.set_wait, s.now_ms, s.levels};
					send_gap = gap_cycles();
				end
			end
			s_tvalid <= nxt_valid;
			s_tdata <= nxt_data;
		end
	end

	// Sink side: compare every result transfer against the oldest prediction.
	int sink_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		logic          nxt_ready;
		press_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			nxt_ready = 1'b1;
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: result with none expected: %h", $realtime, m_tdata);
				end else begin
					want = expected_results.pop_front();
					check_field("release_event", want.release_event, m_tdata[0]);
					check_field("prior_levels", want.prior_levels, m_tdata[4:1]);
					check_field("held_button", want.held_button, m_tdata[7:5]);
					check_field("held_since", want.held_since, m_tdata[39:8]);
					check_field("multi_active", want.multi_active, m_tdata[40]);
					check_field("history_word", want.history_word, m_tdata[64:41]);
					check_field("history_len", want.history_len, m_tdata[68:65]);
				end
				sink_gap = gap_cycles();
			end
			if (sink_gap > 0) begin
				nxt_ready = 1'b0;
				sink_gap--;
			end
			m_tready <= nxt_ready;
		end
	end

	initial begin
		logic [7:0] phase_debounce[5];
		trk_debounce = fbpt_pkg::DEBOUNCE_RESET;
		trk_levels = '0;
		trk_down = 0;
		trk_last_rel = '0;
		trk_held = '0;
		trk_since = '0;
		trk_multi = 1'b0;
		trk_wait = 1'b0;
		press_count = 0;
		for (int k = 0; k < HISTORY_DEPTH; k++)
			press_log[k] = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset debounce of 20 ms.
		queue_sample(4'h0, 32'd0, 1'b0);
		queue_sample(4'h1, 32'd5, 1'b0);
		queue_sample(4'h3, 32'd100, 1'b0);
		queue_sample(4'h0, 32'd150, 1'b0);
		queue_sample(4'h8, 32'd160, 1'b0);
		queue_sample(4'h0, 32'd170, 1'b0);
		queue_sample(4'h4, 32'd191, 1'b0);
		queue_sample(4'h0, 32'd200, 1'b0);
		queue_sample(4'h4, 32'd220, 1'b0);
		queue_sample(4'h0, 32'd230, 1'b0);
		queue_sample(4'h1, 32'd300, 1'b1);
		queue_sample(4'h0, 32'd310, 1'b0);
		queue_sample(4'h0, 32'd320, 1'b1);
		queue_sample(4'h1, 32'd400, 1'b0);
		// Button 0 lets go while the other three go down in the same sample.
		queue_sample(4'hE, 32'd421, 1'b0);
		queue_sample(4'h0, 32'd500, 1'b0);
		queue_sample(4'hF, 32'd600, 1'b0);
		queue_sample(4'h0, 32'hFFFF_FFF0, 1'b0);
		queue_sample(4'h5, 32'h0000_0005, 1'b0);
		queue_sample(4'h4, 32'h0000_0006, 1'b0);
		queue_sample(4'hA, 32'hFFFF_FFFF, 1'b0);
		queue_sample(4'h0, 32'h0000_0014, 1'b0);
		queue_sample(4'h2, 32'h0000_0029, 1'b1);
		queue_sample(4'h0, 32'hAAAA_AAAA, 1'b1);
		queue_sample(4'hF, 32'h5555_5555, 1'b0);
		drain();

		gen_levels = 4'hF;
		gen_clock = 32'h5555_5555;
		gen_last_rel = 32'hAAAA_AAAA;
		phase_debounce[0] = 8'd0;
		phase_debounce[1] = 8'd255;
		phase_debounce[2] = 8'd1;
		phase_debounce[3] = 8'($urandom_range(2, 254));
		phase_debounce[4] = fbpt_pkg::DEBOUNCE_RESET;
		for (int p = 0; p < 5; p++) begin
			write_debounce(phase_debounce[p]);
			no_idle = (p == 2);
			fill_random(RANDOM_PER_PHASE);
			drain();
		end
		repeat (10) @(posedge clk);

		if (mismatch_count == 0)
			$display("tb_four_button_press_tracker_top passed");
		else
			$display("tb_four_button_press_tracker_top failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb_four_button_press_tracker_top failed");
		$finish;
	end

endmodule

/* files.f */
rtl/core/fbpt_pkg.sv
rtl/core/four_button_press_tracker_top.sv
tb/tb_four_button_press_tracker_top.sv
